FILE: src/lrutc_pkg.sv
// ----------------------------------------------------------------------------
// lrutc_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the fully associative recency-ordered tag cache.
// ----------------------------------------------------------------------------
package lrutc_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COORD_W  = 22;
  localparam int HANDLE_W = 16;
  localparam int OP_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Operation codes carried on the request channel.
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROMOTE   = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // register the request
    logic match;       // register the tag compare result
    logic finish;      // apply a non-allocating operation and emit its result
    logic evict;       // evict the least recent entry and emit a result
    logic place;       // write the new entry as most recent
    logic place_emit;  // emit the result of an insert without evictions
  } lrutc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // result register can take a result this cycle
    logic alloc;       // request is an insert of an absent key, non-null handle
    logic need_evict;  // cache is full for the current limit
    logic evict_last;  // the pending eviction is the final one
  } lrutc_stat_t;

endpackage

FILE: src/lrutc_ctrl.sv
// ----------------------------------------------------------------------------
// lrutc_ctrl
// Sequencer for the cache: request capture, tag match, operation execution,
// the eviction loop and placement of a new entry.
// ----------------------------------------------------------------------------
module lrutc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrutc_pkg::lrutc_stat_t stat,
  output lrutc_pkg::lrutc_cmd_t  cmd
);
  import lrutc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_EVICT = 5'b01000,
    S_PLACE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   evicted, evicted_next;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    evicted_next = evicted;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        evicted_next = 1'b0;
        if (stat.alloc) begin
          state_next = stat.need_evict ? S_EVICT : S_PLACE;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EVICT: begin
        if (stat.out_free) begin
          cmd.evict    = 1'b1;
          evicted_next = 1'b1;
          if (stat.evict_last) state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        if (evicted) begin
          cmd.place  = 1'b1;
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.place      = 1'b1;
          cmd.place_emit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      evicted <= 1'b0;
    end else begin
      state   <= state_next;
      evicted <= evicted_next;
    end
  end

endmodule

FILE: src/lrutc_dp.sv
// ----------------------------------------------------------------------------
// lrutc_dp
// Datapath: request registers, the entry array with parallel tag compare and
// recency ranks, configuration registers and the result register.
// ----------------------------------------------------------------------------
module lrutc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  lrutc_pkg::lrutc_cmd_t            cmd,
  output lrutc_pkg::lrutc_stat_t           stat,
  input  logic                             cfg_valid,
  input  logic [lrutc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrutc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [lrutc_pkg::OP_W-1:0]       operation,
  input  logic [lrutc_pkg::COORD_W-1:0]    pos_x,
  input  logic [lrutc_pkg::COORD_W-1:0]    pos_z,
  input  logic [lrutc_pkg::HANDLE_W-1:0]   payload_handle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic                             entry_dirty,
  output logic [lrutc_pkg::HANDLE_W-1:0]   entry_payload,
  output logic                             evict_valid,
  output logic [lrutc_pkg::COORD_W-1:0]    evict_x,
  output logic [lrutc_pkg::COORD_W-1:0]    evict_z,
  output logic [lrutc_pkg::HANDLE_W-1:0]   evict_payload,
  output logic                             evict_dirty,
  output logic [lrutc_pkg::CNT_W-1:0]      occupancy,
  output logic                             last
);
  import lrutc_pkg::*;

  // Entry array.
  logic                slot_valid   [CAPACITY];
  logic                slot_dirty   [CAPACITY];
  logic [COORD_W-1:0]  slot_x       [CAPACITY];
  logic [COORD_W-1:0]  slot_z       [CAPACITY];
  logic [HANDLE_W-1:0] slot_payload [CAPACITY];
  logic [IDX_W-1:0]    slot_rank    [CAPACITY];
  logic [CNT_W-1:0]    count;

  // Configuration.
  logic [CFG_DATA_W-1:0] max_size;
  logic [CFG_DATA_W-1:0] promote_threshold;

  // Captured request and match result.
  logic [OP_W-1:0]     op_q;
  logic [COORD_W-1:0]  x_q;
  logic [COORD_W-1:0]  z_q;
  logic [HANDLE_W-1:0] h_q;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                hit_dirty;
  logic [HANDLE_W-1:0] hit_payload;
  logic [IDX_W-1:0]    hit_rank;

  logic                match_any;
  logic [IDX_W-1:0]    match_idx;
  logic                victim_any;
  logic [IDX_W-1:0]    victim_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    count_m1;

  // Effective limit is max_size saturated into one to CAPACITY.
  always_comb begin
    if (max_size == '0) begin
      lim = CNT_W'(1);
    end else if (CNT_W'(max_size) > CNT_W'(CAPACITY)) begin
      lim = CNT_W'(CAPACITY);
    end else begin
      lim = CNT_W'(max_size);
    end
  end

  assign count_m1 = count - CNT_W'(1);

  // Priority encoders for tag match, least recent victim and first free slot.
  always_comb begin
    match_any  = 1'b0;
    match_idx  = '0;
    victim_any = 1'b0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_x[i] == x_q && slot_z[i] == z_q) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (slot_valid[i] && slot_rank[i] == count_m1[IDX_W-1:0]) begin
        victim_any = 1'b1;
        victim_idx = IDX_W'(i);
      end
      if (!slot_valid[i]) free_idx = IDX_W'(i);
    end
  end

  // Status back to the controller.
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.alloc      = (op_q == OP_INSERT) && !hit && (h_q != '0);
  assign stat.need_evict = (count >= lim);
  assign stat.evict_last = (count_m1 < lim) || !victim_any;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_size          <= CFG_DATA_W'(CAPACITY);
      promote_threshold <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MAX_SIZE) max_size <= cfg_data;
      if (cfg_index == REG_PROMOTE)  promote_threshold <= cfg_data;
    end
  end

  // Request capture and match registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= operation;
      x_q  <= pos_x;
      z_q  <= pos_z;
      h_q  <= payload_handle;
    end
    if (cmd.match) begin
      hit         <= match_any;
      hit_idx     <= match_idx;
      hit_dirty   <= match_any && slot_dirty[match_idx];
      hit_payload <= match_any ? slot_payload[match_idx] : '0;
      hit_rank    <= slot_rank[match_idx];
    end
  end

  // Entry array updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        slot_valid[i] <= 1'b0;
        slot_dirty[i] <= 1'b0;
      end
    end else begin
      if (cmd.finish && hit) begin
        case (op_q)
          OP_LOOKUP: begin
            if (CNT_W'(count) >= CNT_W'(promote_threshold)) begin
              for (int i = 0; i < CAPACITY; i++) begin
                if (slot_valid[i] && slot_rank[i] < hit_rank)
                  slot_rank[i] <= slot_rank[i] + IDX_W'(1);
              end
              slot_rank[hit_idx] <= '0;
            end
          end
          OP_REMOVE: begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (slot_valid[i] && slot_rank[i] > hit_rank)
                slot_rank[i] <= slot_rank[i] - IDX_W'(1);
            end
            slot_valid[hit_idx] <= 1'b0;
            slot_dirty[hit_idx] <= 1'b0;
            count <= count_m1;
          end
          OP_MARK:  slot_dirty[hit_idx] <= 1'b1;
          OP_CLEAR: slot_dirty[hit_idx] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.evict && victim_any) begin
        slot_valid[victim_idx] <= 1'b0;
        slot_dirty[victim_idx] <= 1'b0;
        count <= count_m1;
      end
      if (cmd.place) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot_valid[i]) slot_rank[i] <= slot_rank[i] + IDX_W'(1);
        end
        slot_valid[free_idx]   <= 1'b1;
        slot_dirty[free_idx]   <= 1'b0;
        slot_x[free_idx]       <= x_q;
        slot_z[free_idx]       <= z_q;
        slot_payload[free_idx] <= h_q;
        slot_rank[free_idx]    <= '0;
        count <= count + CNT_W'(1);
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish || cmd.evict || cmd.place_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found         <= hit;
      entry_dirty   <= hit_dirty;
      entry_payload <= hit_payload;
      evict_valid   <= 1'b0;
      evict_x       <= '0;
      evict_z       <= '0;
      evict_payload <= '0;
      evict_dirty   <= 1'b0;
      occupancy     <= (hit && op_q == OP_REMOVE) ? count_m1 : count;
      last          <= 1'b1;
    end else if (cmd.evict) begin
      found         <= 1'b0;
      entry_dirty   <= 1'b0;
      entry_payload <= '0;
      evict_valid   <= 1'b1;
      evict_x       <= slot_x[victim_idx];
      evict_z       <= slot_z[victim_idx];
      evict_payload <= slot_payload[victim_idx];
      evict_dirty   <= slot_dirty[victim_idx];
      occupancy     <= count;
      last          <= stat.evict_last;
    end else if (cmd.place_emit) begin
      found         <= 1'b0;
      entry_dirty   <= 1'b0;
      entry_payload <= '0;
      evict_valid   <= 1'b0;
      evict_x       <= '0;
      evict_z       <= '0;
      evict_payload <= '0;
      evict_dirty   <= 1'b0;
      occupancy     <= count + CNT_W'(1);
      last          <= 1'b1;
    end
  end

endmodule

FILE: src/lru_tag_cache_with_dirty_core.sv
// ----------------------------------------------------------------------------
// lru_tag_cache_with_dirty_core
// Fully associative 32-entry cache keyed by (pos_x, pos_z) with dirty marks
// and recency ranks.
// ----------------------------------------------------------------------------
// One request is handled at a time. A lookup, remove, mark dirty, clear dirty,
// an unknown operation, or an insert that places nothing passes through
// capture, parallel tag compare over all entries, and execute; the execute
// step registers its result once the output register can take it. An insert
// that places a new entry without eviction adds a place step after execute,
// which writes the entry and registers its result. An insert that must evict
// adds an eviction step per evicted entry, since the eviction loop searches
// the rank array for the least recent entry once per cycle while the output
// register can take a result, and emits one result each time. The new entry
// is placed in the cycle after the final eviction.
// Results wait in an output register, so a stalled consumer only holds the
// sequencer when the next result is ready to be written.
module lru_tag_cache_with_dirty_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lrutc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrutc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lrutc_pkg::OP_W-1:0]       operation,
  input  logic [lrutc_pkg::COORD_W-1:0]    pos_x,
  input  logic [lrutc_pkg::COORD_W-1:0]    pos_z,
  input  logic [lrutc_pkg::HANDLE_W-1:0]   payload_handle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic                             entry_dirty,
  output logic [lrutc_pkg::HANDLE_W-1:0]   entry_payload,
  output logic                             evict_valid,
  output logic [lrutc_pkg::COORD_W-1:0]    evict_x,
  output logic [lrutc_pkg::COORD_W-1:0]    evict_z,
  output logic [lrutc_pkg::HANDLE_W-1:0]   evict_payload,
  output logic                             evict_dirty,
  output logic [lrutc_pkg::CNT_W-1:0]      occupancy,
  output logic                             last
);
  import lrutc_pkg::*;

  lrutc_cmd_t  cmd;
  lrutc_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  lrutc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrutc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .pos_x          (pos_x),
    .pos_z          (pos_z),
    .payload_handle (payload_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .entry_dirty    (entry_dirty),
    .entry_payload  (entry_payload),
    .evict_valid    (evict_valid),
    .evict_x        (evict_x),
    .evict_z        (evict_z),
    .evict_payload  (evict_payload),
    .evict_dirty    (evict_dirty),
    .occupancy      (occupancy),
    .last           (last)
  );

  // An eviction result never reports a found entry.
  a_evict_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && evict_valid |-> !found)
    else $error("eviction result reports a found entry");

  // Occupancy never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // A new request is not taken in the cycle after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

endmodule
